[rtl/frd_pkg.sv]
// Shared types and constants for the fraction reduction core.
package frd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-2:0] MAXPOS   = {(DATA_WIDTH-1){1'b1}};

  // Input beat
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_numerator;
    logic signed [DATA_WIDTH-1:0] in_denominator;
  } frd_in_t;

  // Output beat
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_numerator;
    logic [DATA_WIDTH-2:0]        out_denominator;
  } frd_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input beat
    logic strip;      // drop a common factor of two
    logic reduce;     // one binary gcd step
    logic set_g;      // g = a << k
    logic div_init;   // start the divider
    logic div_sel_d;  // dividend: 0 numerator magnitude, 1 denominator magnitude
    logic div_step;   // one quotient bit
    logic save_qn;    // keep numerator quotient
    logic write_out;  // load output register
  } frd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic nm_zero;
    logic dm_zero;
    logic both_even;
    logic gcd_equal;
    logic div_last;
  } frd_sts_t;

endpackage

[rtl/fraction_reduce_gcd_core.sv]
// A fraction goes from load through a zero check straight to the output when either part is zero,
// otherwise through factor-of-two stripping, binary gcd steps and two bit-serial divisions (W = 32).
// Throughput: one fraction at a time; the next beat can be taken once out_valid rises, as in_ready
// returns with it; the gcd loop and bit-serial divider set it, and a stalled output holds the core.
// Reset (rst, synchronous, active high) returns the controller to idle and drops out_valid.
// Top level: fraction reduction by greatest common divisor.
module fraction_reduce_gcd_core import frd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  frd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output frd_out_t out_data
);

  frd_cmd_t cmd;
  frd_sts_t sts;

  // Sequencer
  frd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic
  frd_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[rtl/frd_datapath.sv]
// Datapath: magnitudes, binary gcd registers, shared restoring divider, output register.
module frd_datapath import frd_pkg::*; (
  input  logic     clk,
  input  frd_in_t  in_data,
  input  frd_cmd_t cmd,
  output frd_sts_t sts,
  output frd_out_t out_data
);

  logic [DATA_WIDTH-1:0] nm, dm, a, b, g, rem, quo, qn;
  logic [DATA_WIDTH-1:0] n_raw;
  logic [CNT_W-1:0]      k, cnt;
  logic                  neg, nzero, dzero;

  logic [DATA_WIDTH-1:0] mag_n, mag_d, a_minus_b, b_minus_a;
  logic [DATA_WIDTH:0]   rem_sh, diff;
  logic                  a_gt_b;
  frd_out_t              res;

  // Input magnitudes; the most negative value maps to 2^(W-1) exactly
  assign mag_n = in_data.in_numerator[DATA_WIDTH-1] ?
                 (~in_data.in_numerator + 1'b1) : in_data.in_numerator;
  assign mag_d = in_data.in_denominator[DATA_WIDTH-1] ?
                 (~in_data.in_denominator + 1'b1) : in_data.in_denominator;

  // Binary gcd step terms
  assign a_minus_b = a - b;
  assign b_minus_a = b - a;
  assign a_gt_b    = a > b;

  // Divider trial subtract
  assign rem_sh = {rem, quo[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, g};

  // Result formatting with saturation of out-of-range magnitudes
  always_comb begin
    res = '0;
    if (nzero) begin
      res.out_numerator   = '0;
      res.out_denominator = (DATA_WIDTH-1)'(1);
    end else if (dzero) begin
      res.out_numerator   = n_raw;
      res.out_denominator = '0;
    end else begin
      if (neg) begin
        res.out_numerator = ~qn + 1'b1;
      end else if (qn[DATA_WIDTH-1]) begin
        res.out_numerator = {1'b0, MAXPOS};
      end else begin
        res.out_numerator = qn;
      end
      res.out_denominator = quo[DATA_WIDTH-1] ? MAXPOS : quo[DATA_WIDTH-2:0];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nm    <= mag_n;
      dm    <= mag_d;
      a     <= mag_n;
      b     <= mag_d;
      k     <= '0;
      neg   <= in_data.in_numerator[DATA_WIDTH-1] ^ in_data.in_denominator[DATA_WIDTH-1];
      n_raw <= in_data.in_numerator;
      nzero <= (mag_n == '0);
      dzero <= (mag_d == '0);
    end else if (cmd.strip) begin
      a <= a >> 1;
      b <= b >> 1;
      k <= k + 1'b1;
    end else if (cmd.reduce) begin
      if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a_gt_b) begin
        a <= a_minus_b >> 1;
      end else begin
        b <= b_minus_a >> 1;
      end
    end

    if (cmd.set_g) begin
      g <= a << k;
    end

    // Divider: one quotient bit per cycle, dividend shifts out of quo
    if (cmd.div_init) begin
      rem <= '0;
      quo <= cmd.div_sel_d ? dm : nm;
      cnt <= CNT_LAST;
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (!diff[DATA_WIDTH]) begin
        rem <= diff[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.save_qn) begin
      qn <= quo;
    end

    if (cmd.write_out) begin
      out_data <= res;
    end
  end

  // Status back to the controller
  assign sts.nm_zero   = nzero;
  assign sts.dm_zero   = dzero;
  assign sts.both_even = !a[0] && !b[0];
  assign sts.gcd_equal = (a == b);
  assign sts.div_last  = (cnt == '0);

endmodule

[rtl/frd_ctrl.sv]
// Controller: sequences load, gcd, two divisions and the output handshake.
module frd_ctrl import frd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  frd_sts_t sts,
  output frd_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE, CHECK, STRIP, GCD, DIVN, SWAP, DIVD, FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == IDLE);
  assign slot_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd = '0;
    case (state)
      IDLE:   cmd.load = in_valid;
      CHECK:  ;
      STRIP: begin
        if (sts.both_even) begin
          cmd.strip = 1'b1;
        end
      end
      GCD: begin
        if (sts.gcd_equal) begin
          cmd.set_g    = 1'b1;
          cmd.div_init = 1'b1;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      DIVN:   cmd.div_step = 1'b1;
      SWAP: begin
        cmd.save_qn   = 1'b1;
        cmd.div_init  = 1'b1;
        cmd.div_sel_d = 1'b1;
      end
      DIVD:   cmd.div_step = 1'b1;
      FINISH: cmd.write_out = slot_free;
      default: cmd = '0;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // Set when a result is written, cleared when the beat is taken
      if (state == FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (sts.nm_zero || sts.dm_zero) begin
            state <= FINISH;
          end else begin
            state <= STRIP;
          end
        end
        STRIP: begin
          if (!sts.both_even) begin
            state <= GCD;
          end
        end
        GCD: begin
          if (sts.gcd_equal) begin
            state <= DIVN;
          end
        end
        DIVN: begin
          if (sts.div_last) begin
            state <= SWAP;
          end
        end
        SWAP: state <= DIVD;
        DIVD: begin
          if (sts.div_last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[rtl/frd_checker.sv]
// Port-level checks for the fraction reduction core, bound to the top level.
module frd_checker import frd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input frd_out_t out_data
);

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // One fraction at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after input beat");

  // Handshake outputs always known out of reset
  a_known_handshake: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_ready, out_valid}))
    else $error("unknown handshake output");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output beat changed while stalled");

endmodule

bind fraction_reduce_gcd_core frd_checker u_frd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/tb_top.sv]
// Self-checking testbench for the fraction reduction core: directed and random fractions.
`timescale 1ns / 1ps

module tb_top;
  import frd_pkg::*;

  localparam int RANDOM_FRACTIONS = 1250;
  localparam int CALM_TAIL        = 150;   // last fractions sent with no idling
  localparam int DRAIN_CYCLES     = 250;   // extra wait after the expected queue empties

  // Expected reduced fractions, in order of acceptance
  class fraction_checker;
    frd_out_t    expected_q[$];
    int unsigned errors;
    int unsigned taken;
    int unsigned checked;

    // Lowest-terms fraction with the sign on the numerator
    function frd_out_t reduce(frd_in_t f);
      logic [63:0] mask;
      logic [63:0] maxpos;
      logic [63:0] n, d, nm, dm, a, b, r, qn, qd;
      logic        nneg, dneg;
      frd_out_t    res;
      mask   = ~64'd0 >> (64 - DATA_WIDTH);
      maxpos = mask >> 1;
      n      = {32'd0, f.in_numerator};
      d      = {32'd0, f.in_denominator};
      nneg   = f.in_numerator[DATA_WIDTH-1];
      dneg   = f.in_denominator[DATA_WIDTH-1];
      nm     = nneg ? ((~n + 64'd1) & mask) : n;
      dm     = dneg ? ((~d + 64'd1) & mask) : d;
      if (nm == 64'd0) begin
        res.out_numerator   = '0;
        res.out_denominator = (DATA_WIDTH-1)'(1);
        return res;
      end
      if (dm == 64'd0) begin
        res.out_numerator   = f.in_numerator;
        res.out_denominator = '0;
        return res;
      end
      // Euclid over the magnitudes
      a = nm;
      b = dm;
      while (b != 64'd0) begin
        r = a % b;
        a = b;
        b = r;
      end
      qn = nm / a;
      qd = dm / a;
      if (qd > maxpos) qd = maxpos;
      if (nneg != dneg) res.out_numerator = DATA_WIDTH'((~qn + 64'd1) & mask);
      else              res.out_numerator = DATA_WIDTH'((qn > maxpos) ? maxpos : qn);
      res.out_denominator = qd[DATA_WIDTH-2:0];
      return res;
    endfunction

    function void note_fraction(frd_in_t f);
      expected_q.push_back(reduce(f));
      taken++;
    endfunction

    function void check_reduced(frd_out_t got);
      frd_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result %0d/%0d, expected none", $time,
                 got.out_numerator, got.out_denominator);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_numerator !== want.out_numerator) begin
        errors++;
        $display("%0t ns: numerator mismatch, expected %0d, actual %0d", $time,
                 want.out_numerator, got.out_numerator);
      end
      if (got.out_denominator !== want.out_denominator) begin
        errors++;
        $display("%0t ns: denominator mismatch, expected %0d, actual %0d", $time,
                 want.out_denominator, got.out_denominator);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  frd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  frd_out_t out_data;

  fraction_checker chk = new();

  bit calm;           // no idling on either side
  int send_gap_pct;
  int stall_pct;

  fraction_reduce_gcd_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Beat monitors, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) chk.note_fraction(in_data);
      if (out_valid && out_ready) chk.check_reduced(out_data);
    end
  end

  // Random magnitude below 2^bits
  function automatic logic [63:0] rand_mag(int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw & ((64'd1 << bits) - 64'd1);
  endfunction

  // Random sign on a magnitude of at most 2^31-1
  function automatic logic signed [31:0] with_sign(logic [63:0] m);
    logic signed [31:0] v;
    v = $signed(m[31:0]);
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  // Present one fraction and hold it until taken
  task automatic send_fraction(input logic signed [31:0] num, input logic signed [31:0] den);
    frd_in_t f;
    f.in_numerator   = num;
    f.in_denominator = den;
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data  <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Extremes, signs and the special cases
  task automatic send_directed();
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    send_fraction(0, 0);                      // zero over zero
    send_fraction(0, 5);                      // zero numerator
    send_fraction(0, -MAXV);
    send_fraction(5, 0);                      // zero denominator passes through
    send_fraction(-MAXV, 0);
    send_fraction(MAXV, 0);
    send_fraction(1, 1);
    send_fraction(-1, 1);
    send_fraction(1, -1);
    send_fraction(-1, -1);
    send_fraction(MAXV, MAXV);
    send_fraction(-MAXV, MAXV);
    send_fraction(MAXV, -MAXV);
    send_fraction(-MAXV, -MAXV);
    send_fraction(MAXV, 1);
    send_fraction(1, -MAXV);
    send_fraction(12, 18);
    send_fraction(-12, 18);
    send_fraction(12, -18);
    send_fraction(32'sd1 <<< 30, 32'sd1 <<< 20);              // many shared factors of two
    send_fraction(32'sd1836311903, 32'sd1134903170);          // long Euclid chain
    send_fraction(-32'sd2147483629, 32'sd2147483587);         // large coprime pair
    send_fraction(32'sd1 <<< 30, -(32'sd3 <<< 28));
    send_fraction(32'sh5555_5555, -32'sh2AAA_AAAA);
  endtask

  // One random fraction, mostly with a shared factor
  task automatic send_random();
    int          kind;
    int          wg, wa, wb, k;
    logic [63:0] g, a, b;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      wg = $urandom_range(1, 30);
      wa = $urandom_range(0, 31 - wg);
      wb = $urandom_range(0, 31 - wg);
      g  = rand_mag(wg);
      if (g == 64'd0) g = 64'd1;
      a  = g * rand_mag(wa);
      b  = g * rand_mag(wb);
    end else if (kind < 62) begin
      // shared power of two
      k = $urandom_range(1, 30);
      a = rand_mag($urandom_range(0, 31 - k)) << k;
      b = rand_mag($urandom_range(0, 31 - k)) << k;
    end else if (kind < 84) begin
      a = rand_mag($urandom_range(1, 31));
      b = rand_mag($urandom_range(1, 31));
    end else if (kind < 89) begin
      a = 64'd0;
      b = rand_mag($urandom_range(0, 31));
    end else if (kind < 94) begin
      a = rand_mag($urandom_range(1, 31));
      b = 64'd0;
    end else begin
      // one part a multiple of the other
      b = rand_mag($urandom_range(1, 16));
      a = b * rand_mag($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) begin
        g = a;
        a = b;
        b = g;
      end
    end
    send_fraction(with_sign(a), with_sign(b));
  endtask

  // Receiver: random stall bursts, stall rate changing over the run
  initial begin
    int cyc;
    cyc       = 0;
    stall_pct = 0;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    calm         = 1'b0;
    send_gap_pct = 20;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();
    for (int i = 0; i < RANDOM_FRACTIONS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 20;
          default: send_gap_pct = 60;
        endcase
      end
      if (i == RANDOM_FRACTIONS - CALM_TAIL) calm = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;

    // Drain, then allow for anything still in flight
    while (chk.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d fractions (directed extremes, zero parts, shared factors, random).",
             chk.taken);
    $display("Compared %0d reduced results with random idling on both sides.", chk.checked);
    if (chk.errors == 0 && chk.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
